// ===== rtl/pprt_pkg.sv =====
// ----------------------------------------------------------------------------
// pprt_pkg
// Shared types and constants for the plating polarity reversal timer.
// ----------------------------------------------------------------------------
package pprt_pkg;

  localparam int MS_W         = 16;
  localparam int SCALE_W      = 10;
  localparam int SAMP_W       = 10;
  localparam int DUTY_W       = 4;
  localparam int STEPS_W      = 8;
  localparam int CNT_W        = $clog2(MS_W);
  localparam int DUTY_RECIP_W = 6;
  localparam int DUTY_SHIFT   = 12;
  localparam int DUTY_PROD_W  = SAMP_W + DUTY_RECIP_W;

  localparam logic [MS_W-1:0]    MS_WRAP          = 16'd50000;
  localparam logic [SCALE_W-1:0] DUTY_DIV         = 10'd100;
  localparam logic [SCALE_W-1:0] SCALE_1          = 10'd1;
  localparam logic [SCALE_W-1:0] SCALE_10         = 10'd10;
  localparam logic [SCALE_W-1:0] SCALE_100        = 10'd100;
  localparam logic [SCALE_W-1:0] SCALE_1000       = 10'd1000;
  localparam logic [STEPS_W-1:0] DIRECT_UNITS_RST = 8'd20;
  // sample / 100 as (sample * 41) >> 12, exact over 10-bit samples
  localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP  = 6'd41;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_ADC    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_X1    = 3'd0,
    MODE_X10   = 3'd1,
    MODE_X100  = 3'd2,
    MODE_X1000 = 3'd3,
    MODE_FDIR  = 3'd4,
    MODE_FREV  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    PH_DUTY    = 2'd0,
    PH_DIRECT  = 2'd1,
    PH_REVERSE = 2'd2,
    PH_IDLE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_DIV   = 2'd1,
    S_APPLY = 2'd2,
    S_DONE  = 2'd3
  } state_t;

endpackage

// ===== rtl/pprt_div.sv =====
// ----------------------------------------------------------------------------
// pprt_div
// Restoring divider, one quotient bit per cycle, giving the remainder of the
// millisecond count against the time scale.
// ----------------------------------------------------------------------------
module pprt_div
  import pprt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MS_W-1:0]    dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               done,
  output logic [SCALE_W-1:0] remainder
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SCALE_W-1:0] dvs;
  logic [SCALE_W-1:0] rem;
  logic [MS_W-1:0]    quo;
  logic [SCALE_W:0]   shifted;
  logic [SCALE_W:0]   diff;
  logic               ge;

  assign shifted   = {rem, quo[MS_W-1]};
  assign ge        = shifted >= {1'b0, dvs};
  assign diff      = shifted - {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[SCALE_W-1:0] : shifted[SCALE_W-1:0];
      quo <= {quo[MS_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/pprt_seq.sv =====
// ----------------------------------------------------------------------------
// pprt_seq
// Item sequencer: accepts a beat, runs the divider when needed, applies the
// state update and hands the result to the output register.
// ----------------------------------------------------------------------------
module pprt_seq
  import pprt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic need_div,
  input  logic out_free,
  input  logic div_done,
  output logic in_ready,
  output logic div_start,
  output logic apply,
  output logic load_out
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = need_div ? S_DIV : S_APPLY;
      end
      S_DIV: begin
        if (div_done) state_next = S_APPLY;
      end
      S_APPLY: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    apply     = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && need_div;
      end
      S_DIV:   ;
      S_APPLY: apply = 1'b1;
      S_DONE:  load_out = out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/plating_polarity_reversal_timer_unit.sv =====
// ----------------------------------------------------------------------------
// plating_polarity_reversal_timer_unit
// Polarity controller for a plating bath: millisecond ticks, mode button and
// converter results drive the direct/reverse cycle and the sampling sequence.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A tick runs the 16-step bit-serial divider that
// forms the millisecond remainder against the time scale before the state update
// is applied and the result is loaded. A button press, an unused kind or a
// converter result skips the divider and goes straight to the state update; the
// duty level comes from a small reciprocal multiply of the sample. The next beat
// is accepted as soon as the result sits in the output register, even while it
// still waits to be taken.
module plating_polarity_reversal_timer_unit
  import pprt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [STEPS_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [SAMP_W-1:0] sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              polarity,
  output logic [2:0]        mode_now,
  output logic [DUTY_W-1:0] duty_level,
  output logic [1:0]        start_channel,
  output logic              value_valid,
  output logic [SAMP_W-1:0] measured_value,
  output logic              value_is_reverse
);

  logic [STEPS_W-1:0] direct_units;
  mode_t              mode_reg,      mode_reg_next;
  logic [SCALE_W-1:0] time_scale,    time_scale_next;
  logic [MS_W-1:0]    ms_count,      ms_count_next;
  logic [DUTY_W-1:0]  duty_setting,  duty_setting_next;
  logic [DUTY_W-1:0]  reverse_steps, reverse_steps_next;
  logic [STEPS_W-1:0] direct_steps,  direct_steps_next;
  logic               polarity_reg,  polarity_reg_next;
  phase_t             adc_phase,     adc_phase_next;

  kind_t              item_kind;
  logic [SAMP_W-1:0]  item_sample;
  phase_t             res_start,     res_start_next;
  logic               res_valid,     res_valid_next;
  logic [SAMP_W-1:0]  res_value,     res_value_next;
  logic               res_rev,       res_rev_next;

  logic               need_div;
  logic               out_free;
  logic               apply;
  logic               load_out;
  logic               div_start;
  logic               div_done;
  logic [SCALE_W-1:0] div_rem;

  logic [MS_W-1:0]        ms_inc;
  logic [DUTY_W-1:0]      rev_inc;
  logic                   timed;
  logic [DUTY_PROD_W-1:0] duty_prod;

  assign ms_inc    = ms_count + 1'b1;
  assign rev_inc   = reverse_steps + 1'b1;
  assign timed     = (mode_reg != MODE_FDIR) && (mode_reg != MODE_FREV);
  assign need_div  = kind_t'(kind) == KIND_TICK;
  assign out_free  = !out_valid || out_ready;
  assign duty_prod = DUTY_PROD_W'(item_sample) * DUTY_PROD_W'(DUTY_RECIP);

  pprt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .need_div  (need_div),
    .out_free  (out_free),
    .div_done  (div_done),
    .in_ready  (in_ready),
    .div_start (div_start),
    .apply     (apply),
    .load_out  (load_out)
  );

  pprt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ms_inc),
    .divisor   (time_scale),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_kind   <= kind_t'(kind);
      item_sample <= sample;
    end
  end

  always_comb begin
    mode_reg_next      = mode_reg;
    time_scale_next    = time_scale;
    ms_count_next      = ms_count;
    duty_setting_next  = duty_setting;
    reverse_steps_next = reverse_steps;
    direct_steps_next  = direct_steps;
    polarity_reg_next  = polarity_reg;
    adc_phase_next     = adc_phase;
    res_start_next     = PH_IDLE;
    res_valid_next     = 1'b0;
    res_value_next     = '0;
    res_rev_next       = 1'b0;
    case (item_kind)
      KIND_TICK: begin
        if (div_rem == '0) begin
          if (direct_steps == direct_units) begin
            if (duty_setting != '0 && reverse_steps == '0 && timed) begin
              polarity_reg_next = 1'b0;
              adc_phase_next    = PH_IDLE;
            end
            reverse_steps_next = rev_inc;
            if (rev_inc > duty_setting) begin
              reverse_steps_next = '0;
              direct_steps_next  = '0;
              if (timed) begin
                polarity_reg_next = 1'b1;
                adc_phase_next    = PH_IDLE;
              end
            end
          end else begin
            direct_steps_next = direct_steps + 1'b1;
          end
        end
        ms_count_next = (ms_inc == MS_WRAP) ? '0 : ms_inc;
      end
      KIND_BUTTON: begin
        case (mode_reg)
          MODE_X1: begin
            mode_reg_next   = MODE_X10;
            time_scale_next = SCALE_10;
          end
          MODE_X10: begin
            mode_reg_next   = MODE_X100;
            time_scale_next = SCALE_100;
          end
          MODE_X100: begin
            mode_reg_next   = MODE_X1000;
            time_scale_next = SCALE_1000;
          end
          MODE_X1000: begin
            mode_reg_next     = MODE_FDIR;
            time_scale_next   = SCALE_1;
            polarity_reg_next = 1'b1;
            adc_phase_next    = PH_IDLE;
          end
          MODE_FDIR: begin
            mode_reg_next     = MODE_FREV;
            time_scale_next   = SCALE_1;
            polarity_reg_next = 1'b0;
            adc_phase_next    = PH_IDLE;
          end
          MODE_FREV: begin
            mode_reg_next   = MODE_X1;
            time_scale_next = SCALE_1;
          end
          default: ;
        endcase
      end
      KIND_ADC: begin
        case (adc_phase)
          PH_DUTY: begin
            duty_setting_next = duty_prod[DUTY_SHIFT +: DUTY_W];
            adc_phase_next    = polarity_reg ? PH_DIRECT : PH_REVERSE;
          end
          PH_DIRECT: begin
            res_valid_next = 1'b1;
            res_value_next = item_sample;
            adc_phase_next = PH_DUTY;
          end
          PH_REVERSE: begin
            res_valid_next = 1'b1;
            res_value_next = item_sample;
            res_rev_next   = 1'b1;
            adc_phase_next = PH_DUTY;
          end
          default: adc_phase_next = PH_DUTY;
        endcase
        res_start_next = adc_phase_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_units  <= DIRECT_UNITS_RST;
      mode_reg      <= MODE_FDIR;
      time_scale    <= SCALE_100;
      ms_count      <= '0;
      duty_setting  <= '0;
      reverse_steps <= '0;
      direct_steps  <= '0;
      polarity_reg  <= 1'b1;
      adc_phase     <= PH_DUTY;
    end else begin
      if (cfg_we) direct_units <= cfg_wdata;
      if (apply) begin
        mode_reg      <= mode_reg_next;
        time_scale    <= time_scale_next;
        ms_count      <= ms_count_next;
        duty_setting  <= duty_setting_next;
        reverse_steps <= reverse_steps_next;
        direct_steps  <= direct_steps_next;
        polarity_reg  <= polarity_reg_next;
        adc_phase     <= adc_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      res_start <= res_start_next;
      res_valid <= res_valid_next;
      res_value <= res_value_next;
      res_rev   <= res_rev_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      polarity         <= polarity_reg;
      mode_now         <= mode_reg;
      duty_level       <= duty_setting;
      start_channel    <= res_start;
      value_valid      <= res_valid;
      measured_value   <= res_value;
      value_is_reverse <= res_rev;
    end
  end

endmodule

// ===== rtl/pprt_chk.sv =====
// ----------------------------------------------------------------------------
// pprt_chk
// Port-level checks for the polarity reversal timer, bound to the top level.
// ----------------------------------------------------------------------------
module pprt_chk
  import pprt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] duty_level,
  input logic [1:0]        start_channel,
  input logic              value_valid,
  input logic [SAMP_W-1:0] measured_value,
  input logic              value_is_reverse
);

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before accept");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // no report without a measurement
  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_valid |-> measured_value == '0 && value_is_reverse == 1'b0)
    else $error("measurement fields set without a report");

  // a reported measurement restarts the duty conversion
  a_report_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_valid |-> start_channel == PH_DUTY)
    else $error("report not followed by duty conversion");

  // duty level stays within sample range divided by 100
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_level <= 4'd10)
    else $error("duty level out of range");

endmodule

bind plating_polarity_reversal_timer_unit pprt_chk u_pprt_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .duty_level       (duty_level),
  .start_channel    (start_channel),
  .value_valid      (value_valid),
  .measured_value   (measured_value),
  .value_is_reverse (value_is_reverse)
);
